// ----- rtl/core/daily_close_indicator_buy_signal_assert.svh -----
// assertion macros for the day-close buy signal block
// used by the checker module only
`ifndef DAILY_CLOSE_INDICATOR_BUY_SIGNAL_ASSERT_SVH
`define DAILY_CLOSE_INDICATOR_BUY_SIGNAL_ASSERT_SVH
// implication checked every clock outside reset
`define DCB_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define DCB_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

// ----- rtl/core/dcb_pkg.sv -----
// shared types and constants for the day-close buy signal block
// no dependencies
package dcb_pkg;
    localparam int CLOSE_DEPTH_DEF = 128;
    localparam int DAY_MS_DEF      = 86400000;

    localparam logic [1:0] ST_DECIDED  = 2'd0;
    localparam logic [1:0] ST_DISABLED = 2'd1;
    localparam logic [1:0] ST_FEW      = 2'd2;

    localparam logic [1:0] REG_ENABLED = 2'd0;
    localparam logic [1:0] REG_LIMIT   = 2'd1;
    localparam logic [1:0] REG_WINDOW  = 2'd2;
    localparam logic [1:0] REG_GAP     = 2'd3;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_DECIDE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_SAMPLE, S_START, S_READ, S_ACC, S_DIV_START, S_DIV_WAIT,
        S_RESULT, S_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic sample;      // apply accepted sample
        logic start;       // begin a walk
        logic rd;          // issue ring read
        logic acc;         // accumulate read entry
        logic div_start;   // launch divisions
        logic finish;      // form result
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic more;        // more entries left to read
        logic stop;        // read entry older than window
        logic few;         // walk done with under three closes
        logic div_done;    // divisions done
    } t_sts;
endpackage

// ----- rtl/core/dcb_if.sv -----
// valid/ready channel interface carrying a generic payload
// depends on nothing
interface dcb_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/dcb_div.sv -----
// restoring radix-2 divider, one quotient bit a cycle
// depends on nothing
module dcb_div #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  r_quo, n_quo;
    logic [W:0]    r_rem, n_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W:0]    w_sh;

    // shift and subtract step
    always_comb begin
        w_sh  = {r_rem[W-1:0], r_quo[W-1]};
        n_quo = {r_quo[W-2:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem    = w_sh - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = !r_busy;
    assign o_quo  = r_quo;
endmodule

// ----- rtl/core/dcb_ctrl.sv -----
// controller state machine for the day-close buy signal block
// depends on dcb_pkg
module dcb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_op,
    input  logic           i_out_ready,
    input  dcb_pkg::t_sts  i_sts,
    input  logic           i_enabled,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output dcb_pkg::t_cmd  o_cmd
);
    dcb_pkg::t_state r_state, n_state;
    logic w_acc_in;

    assign w_acc_in = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= dcb_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dcb_pkg::S_IDLE: begin
                if (w_acc_in) begin
                    if (i_in_op == dcb_pkg::OP_SAMPLE) n_state = dcb_pkg::S_SAMPLE;
                    else if (!i_enabled)               n_state = dcb_pkg::S_RESULT;
                    else                               n_state = dcb_pkg::S_START;
                end
            end
            dcb_pkg::S_SAMPLE: n_state = dcb_pkg::S_IDLE;
            dcb_pkg::S_START: begin
                if (i_sts.more) n_state = dcb_pkg::S_READ;
                else            n_state = dcb_pkg::S_DIV_START;
            end
            dcb_pkg::S_READ: n_state = dcb_pkg::S_ACC;
            dcb_pkg::S_ACC: begin
                if (i_sts.stop || !i_sts.more) n_state = dcb_pkg::S_DIV_START;
                else                           n_state = dcb_pkg::S_READ;
            end
            dcb_pkg::S_DIV_START: begin
                if (i_sts.few) n_state = dcb_pkg::S_RESULT;
                else           n_state = dcb_pkg::S_DIV_WAIT;
            end
            dcb_pkg::S_DIV_WAIT: if (i_sts.div_done) n_state = dcb_pkg::S_RESULT;
            dcb_pkg::S_RESULT: n_state = dcb_pkg::S_OUT;
            dcb_pkg::S_OUT: if (i_out_ready) n_state = dcb_pkg::S_IDLE;
            default: n_state = dcb_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            dcb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.start = w_acc_in;
                o_cmd.sample = w_acc_in && (i_in_op == dcb_pkg::OP_SAMPLE);
            end
            dcb_pkg::S_READ:      o_cmd.rd = 1'b1;
            dcb_pkg::S_ACC:       o_cmd.acc = 1'b1;
            dcb_pkg::S_DIV_START: o_cmd.div_start = 1'b1;
            dcb_pkg::S_RESULT:    o_cmd.finish = 1'b1;
            dcb_pkg::S_OUT:       o_out_valid = 1'b1;
            default: o_cmd = '0;
        endcase
    end
endmodule

// ----- rtl/core/dcb_dp.sv -----
// datapath: close rings, window walk, accumulators, dividers, result
// depends on dcb_pkg and dcb_div
module dcb_dp #(
    parameter int CLOSE_DEPTH = dcb_pkg::CLOSE_DEPTH_DEF,
    parameter int DAY_MS      = dcb_pkg::DAY_MS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dcb_pkg::t_cmd i_cmd,
    input  logic          i_in_op,
    input  logic [47:0]   i_timestamp,
    input  logic [31:0]   i_price,
    input  logic          i_enabled,
    input  logic [13:0]   i_rsi_limit,
    input  logic [6:0]    i_window_days,
    input  logic [26:0]   i_night_gap,
    output dcb_pkg::t_sts o_sts,
    output logic          o_buy,
    output logic [1:0]    o_status,
    output logic [31:0]   o_mean_close,
    output logic [31:0]   o_weighted_mean_close,
    output logic [13:0]   o_rsi_hundredths,
    output logic [7:0]    o_close_count
);
    localparam int AW = $clog2(CLOSE_DEPTH);
    localparam int CW = $clog2(CLOSE_DEPTH + 1);
    localparam int DW = 64;

    // close rings
    logic [47:0]   r_tring [CLOSE_DEPTH];
    logic [31:0]   r_pring [CLOSE_DEPTH];
    logic [AW-1:0] r_wp;
    logic [CW-1:0] r_fill;
    logic [47:0]   r_lt;
    logic [31:0]   r_lp;
    logic          r_have;

    // walk state
    logic [47:0]   r_lim;
    logic [31:0]   r_price;
    logic [AW-1:0] r_ra;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_n;
    logic [47:0]   r_rt;
    logic [31:0]   r_rp, r_newer;
    logic [47:0]   r_sum, r_gain, r_loss;
    logic [55:0]   r_wsum;
    logic          r_stop, r_dis;
    logic [47:0]   w_span;
    logic [CW-1:0] w_n1;
    logic [47:0]   w_gap;

    assign w_span = 48'(i_window_days) * 48'(DAY_MS);
    assign w_gap  = i_timestamp - r_lt;

    // sample handling and ring writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
            r_lt   <= '0;
            r_lp   <= '0;
            r_have <= 1'b0;
        end else if (i_cmd.sample) begin
            if (r_have && i_timestamp >= r_lt && w_gap >= 48'(i_night_gap)) begin
                r_wp <= (r_wp == AW'(CLOSE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                if (r_fill != CW'(CLOSE_DEPTH)) r_fill <= r_fill + 1'b1;
            end
            r_lt   <= i_timestamp;
            r_lp   <= i_price;
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sample && r_have && i_timestamp >= r_lt &&
            w_gap >= 48'(i_night_gap)) begin
            r_tring[r_wp] <= r_lt;
            r_pring[r_wp] <= r_lp;
        end
        if (i_cmd.rd) begin
            r_rt <= r_tring[r_ra];
            r_rp <= r_pring[r_ra];
        end
    end

    assign w_n1 = r_n + 1'b1;

    // walk control and accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.start && i_in_op == dcb_pkg::OP_DECIDE) begin
            r_price <= i_price;
            r_lim   <= (i_timestamp >= w_span) ? i_timestamp - w_span : '0;
            r_ra    <= (r_wp == '0) ? AW'(CLOSE_DEPTH - 1) : r_wp - 1'b1;
            r_k     <= '0;
            r_n     <= '0;
            r_sum   <= '0;
            r_wsum  <= '0;
            r_gain  <= '0;
            r_loss  <= '0;
            r_stop  <= 1'b0;
            r_dis   <= !i_enabled;
        end
        if (i_cmd.rd) begin
            r_k  <= r_k + 1'b1;
            r_ra <= (r_ra == '0) ? AW'(CLOSE_DEPTH - 1) : r_ra - 1'b1;
        end
        if (i_cmd.acc) begin
            if (r_rt < r_lim) begin
                r_stop <= 1'b1;
            end else begin
                r_n    <= w_n1;
                r_sum  <= r_sum + 48'(r_rp);
                r_wsum <= r_wsum + 56'(r_rp) * 56'(w_n1);
                r_newer <= r_rp;
                if (r_n != '0) begin
                    if (r_newer > r_rp) r_gain <= r_gain + 48'(r_newer - r_rp);
                    else                r_loss <= r_loss + 48'(r_rp - r_newer);
                end
            end
        end
    end

    assign o_sts.more = (r_k < r_fill) && !r_stop;
    assign o_sts.stop = r_rt < r_lim;
    assign o_sts.few  = r_n < CW'(3);

    // dividers and comparison products
    logic [DW-1:0] w_q0, w_q1, w_q2;
    logic          w_d0, w_d1, w_d2;
    logic [23:0]   w_wtot;
    logic [63:0]   r_pn, r_pw, r_gl, r_lt2;
    logic [47:0]   w_tot;

    assign w_wtot = 24'((32'(r_n) * 32'(w_n1)) >> 1);
    assign w_tot  = r_gain + r_loss;

    dcb_div #(.W(DW)) u_div0 (.i_clk, .i_rst_n, .i_start(i_cmd.div_start),
        .i_num(64'(r_sum)), .i_den(64'(r_n)), .o_done(w_d0), .o_quo(w_q0));
    dcb_div #(.W(DW)) u_div1 (.i_clk, .i_rst_n, .i_start(i_cmd.div_start),
        .i_num(64'(r_wsum)), .i_den(64'(w_wtot)), .o_done(w_d1), .o_quo(w_q1));
    dcb_div #(.W(DW)) u_div2 (.i_clk, .i_rst_n, .i_start(i_cmd.div_start),
        .i_num(64'(r_gain) * 64'd10000), .i_den(64'(w_tot)),
        .o_done(w_d2), .o_quo(w_q2));

    assign o_sts.div_done = w_d0 && w_d1 && w_d2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_pn  <= 64'(r_price) * 64'(r_n);
            r_pw  <= 64'(r_price) * 64'(w_wtot);
            r_gl  <= 64'(r_gain) * 64'd10000;
            r_lt2 <= 64'(i_rsi_limit) * 64'(w_tot);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_buy                 <= 1'b0;
            o_mean_close          <= '0;
            o_weighted_mean_close <= '0;
            o_rsi_hundredths      <= '0;
            o_close_count         <= '0;
            if (r_dis) begin
                o_status <= dcb_pkg::ST_DISABLED;
            end else if (r_n < CW'(3)) begin
                o_status      <= dcb_pkg::ST_FEW;
                o_close_count <= 8'(r_n);
            end else begin
                o_status              <= dcb_pkg::ST_DECIDED;
                o_close_count         <= 8'(r_n);
                o_mean_close          <= w_q0[31:0];
                o_weighted_mean_close <= w_q1[31:0];
                o_rsi_hundredths      <= (r_loss == '0) ? 14'd10000 : w_q2[13:0];
                o_buy <= (r_pn >= 64'(r_sum)) && (r_pw >= 64'(r_wsum)) &&
                    ((r_loss == '0) ? (i_rsi_limit >= 14'd10000) : (r_gl <= r_lt2));
            end
        end
    end
endmodule

// ----- rtl/core/daily_close_indicator_buy_signal.sv -----
// Day-close buy signal: a sample makes at most one ring write; an enabled decide
// walks the newest closes in the window one at a time, then runs shared-start
// dividers. One item is in work at a time; the result is held until taken.
// No clearing pass after reset.
// depends on dcb_pkg, dcb_if, dcb_ctrl, dcb_dp
module daily_close_indicator_buy_signal #(
    parameter int CLOSE_DEPTH = dcb_pkg::CLOSE_DEPTH_DEF,
    parameter int DAY_MS      = dcb_pkg::DAY_MS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dcb_if.sink         in_ch,
    dcb_if.source       out_ch,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic        r_enabled;
    logic [13:0] r_rsi_limit;
    logic [6:0]  r_window_days;
    logic [26:0] r_night_gap;
    dcb_pkg::t_cmd w_cmd;
    dcb_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled     <= 1'b0;
            r_rsi_limit   <= 14'd3000;
            r_window_days <= 7'd7;
            r_night_gap   <= 27'd7200000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dcb_pkg::REG_ENABLED: r_enabled     <= i_cfg_data[0];
                dcb_pkg::REG_LIMIT:   r_rsi_limit   <= i_cfg_data[13:0];
                dcb_pkg::REG_WINDOW:  r_window_days <= i_cfg_data[6:0];
                dcb_pkg::REG_GAP:     r_night_gap   <= i_cfg_data[26:0];
                default: r_enabled <= r_enabled;
            endcase
        end
    end

    dcb_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(in_ch.valid), .i_in_op(in_ch.data.operation),
        .i_out_ready(out_ch.ready), .i_sts(w_sts), .i_enabled(r_enabled),
        .o_in_ready(in_ch.ready), .o_out_valid(out_ch.valid), .o_cmd(w_cmd)
    );

    dcb_dp #(.CLOSE_DEPTH(CLOSE_DEPTH), .DAY_MS(DAY_MS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd),
        .i_in_op(in_ch.data.operation), .i_timestamp(in_ch.data.timestamp),
        .i_price(in_ch.data.price), .i_enabled(r_enabled),
        .i_rsi_limit(r_rsi_limit), .i_window_days(r_window_days),
        .i_night_gap(r_night_gap), .o_sts(w_sts),
        .o_buy(out_ch.data.buy), .o_status(out_ch.data.status),
        .o_mean_close(out_ch.data.mean_close),
        .o_weighted_mean_close(out_ch.data.weighted_mean_close),
        .o_rsi_hundredths(out_ch.data.rsi_hundredths),
        .o_close_count(out_ch.data.close_count)
    );
endmodule

// ----- rtl/core/dcb_checker.sv -----
// port-level checker for the day-close buy signal block, bound to the top
// depends on dcb_pkg and the assertion macro header
`include "daily_close_indicator_buy_signal_assert.svh"
module dcb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic        buy
);
    `DCB_ASSERT_IMPL(a_no_in_while_out, i_clk, i_rst_n, out_valid, !in_ready)
    `DCB_ASSERT_IMPL(a_status_legal, i_clk, i_rst_n, out_valid,
        status == dcb_pkg::ST_DECIDED || status == dcb_pkg::ST_DISABLED ||
        status == dcb_pkg::ST_FEW)
    `DCB_ASSERT_IMPL(a_buy_decided, i_clk, i_rst_n, out_valid && buy,
        status == dcb_pkg::ST_DECIDED)
    `DCB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
endmodule

bind daily_close_indicator_buy_signal dcb_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(out_ch.data.status), .buy(out_ch.data.buy)
);
